[rtl/core/patsp_pkg.sv]
// patsp_pkg: beat types and result codes shared by the pat section parser
// no dependencies; used by patsp_parse and pat_section_parser
`timescale 1ns / 1ps
`default_nettype none

package patsp_pkg;

   // result kind codes
   localparam logic KIND_ENTRY   = 1'b0;
   localparam logic KIND_SUMMARY = 1'b1;

   // header byte positions within a section
   localparam logic [11:0] POS_TBL_ID   = 12'd0;
   localparam logic [11:0] POS_SYNTAX   = 12'd1;
   localparam logic [11:0] POS_LENGTH   = 12'd2;
   localparam logic [11:0] POS_STREAM   = 12'd4;
   localparam logic [11:0] POS_VERSION  = 12'd5;
   localparam logic [11:0] POS_SECTION  = 12'd6;
   localparam logic [11:0] POS_LAST     = 12'd7;
   localparam logic [11:0] POS_ENTRIES  = 12'd8;

   // header overhead after the length field, and crc tail offset
   localparam logic [11:0] LEN_OVERHEAD = 12'd9;
   localparam logic [11:0] CRC_LAST_OFF = 12'd3;
   localparam logic [1:0]  ENTRY_LAST   = 2'd3;

   // input beat
   typedef struct packed {
      logic [7:0] data_byte;
      logic       section_start;
   } req_type;

   // result beat
   typedef struct packed {
      logic        kind;
      logic [15:0] prog_num;
      logic [12:0] pid;
      logic [7:0]  tbl_id;
      logic        syntax_indicator;
      logic [11:0] sect_len;
      logic [15:0] stream_id;
      logic [4:0]  ver_num;
      logic        current_next;
      logic [7:0]  sect_num;
      logic [7:0]  last_sect_num;
      logic [31:0] crc_word;
   } rsp_type;

endpackage

`default_nettype wire

[rtl/core/patsp_parse.sv]
// patsp_parse: section byte tracker, header field capture and result forming
// depends on patsp_pkg
`timescale 1ns / 1ps
`default_nettype none

module patsp_parse (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              step,
   input  wire patsp_pkg::req_type beat,
   output logic                   res_valid,
   output patsp_pkg::rsp_type     res
);

   logic [11:0] byte_position_ff, byte_position_in;
   logic        in_section_ff, in_section_in;
   logic [7:0]  hdr_tbl_id_ff, hdr_tbl_id_in;
   logic        hdr_syntax_ff, hdr_syntax_in;
   logic [11:0] hdr_length_ff, hdr_length_in;
   logic [15:0] hdr_stream_id_ff, hdr_stream_id_in;
   logic [4:0]  hdr_version_ff, hdr_version_in;
   logic        hdr_current_next_ff, hdr_current_next_in;
   logic [7:0]  hdr_sect_num_ff, hdr_sect_num_in;
   logic [7:0]  hdr_last_section_ff, hdr_last_section_in;
   logic [9:0]  entry_total_ff, entry_total_in;
   logic [23:0] gather_shift_ff, gather_shift_in;

   logic        active;
   logic [11:0] pos;
   logic [11:0] off;
   logic [11:0] span;
   logic [11:0] tail;
   logic [11:0] new_length;
   logic [11:0] len_less;
   logic        is_entry;
   logic        is_summary;
   logic [7:0]  b;

   // current position and section span
   always_comb begin
      b          = beat.data_byte;
      active     = beat.section_start | in_section_ff;
      pos        = beat.section_start ? '0 : byte_position_ff;
      off        = pos - patsp_pkg::POS_ENTRIES;
      span       = {entry_total_ff, 2'b00};
      tail       = off - span;
      new_length = {gather_shift_ff[3:0], b};
      len_less   = new_length - patsp_pkg::LEN_OVERHEAD;
      is_entry   = active && (pos >= patsp_pkg::POS_ENTRIES) && (off < span)
                   && (off[1:0] == patsp_pkg::ENTRY_LAST);
      is_summary = active && (pos >= patsp_pkg::POS_ENTRIES) && (off >= span)
                   && (tail == patsp_pkg::CRC_LAST_OFF);
   end

   // result forming
   always_comb begin
      res       = '0;
      res_valid = is_entry | is_summary;
      if (is_summary) begin
         res.kind             = patsp_pkg::KIND_SUMMARY;
         res.tbl_id           = hdr_tbl_id_ff;
         res.syntax_indicator = hdr_syntax_ff;
         res.sect_len         = hdr_length_ff;
         res.stream_id        = hdr_stream_id_ff;
         res.ver_num          = hdr_version_ff;
         res.current_next     = hdr_current_next_ff;
         res.sect_num         = hdr_sect_num_ff;
         res.last_sect_num    = hdr_last_section_ff;
         res.crc_word         = {gather_shift_ff, b};
      end else begin
         res.kind     = patsp_pkg::KIND_ENTRY;
         res.prog_num = gather_shift_ff[23:8];
         res.pid      = (gather_shift_ff[23:8] != 16'd0) ?
                        {gather_shift_ff[4:0], b} : 13'd0;
      end
   end

   // state update for an accepted byte
   always_comb begin
      byte_position_in    = byte_position_ff;
      in_section_in       = in_section_ff;
      hdr_tbl_id_in       = hdr_tbl_id_ff;
      hdr_syntax_in       = hdr_syntax_ff;
      hdr_length_in       = hdr_length_ff;
      hdr_stream_id_in    = hdr_stream_id_ff;
      hdr_version_in      = hdr_version_ff;
      hdr_current_next_in = hdr_current_next_ff;
      hdr_sect_num_in     = hdr_sect_num_ff;
      hdr_last_section_in = hdr_last_section_ff;
      entry_total_in      = entry_total_ff;
      gather_shift_in     = gather_shift_ff;
      if (step && active) begin
         in_section_in    = 1'b1;
         gather_shift_in  = {gather_shift_ff[15:0], b};
         byte_position_in = pos + 12'd1;
         priority if (pos == patsp_pkg::POS_TBL_ID) begin
            hdr_tbl_id_in = b;
         end else if (pos == patsp_pkg::POS_SYNTAX) begin
            hdr_syntax_in = b[7];
         end else if (pos == patsp_pkg::POS_LENGTH) begin
            hdr_length_in  = new_length;
            entry_total_in = (new_length >= patsp_pkg::LEN_OVERHEAD) ?
                             len_less[11:2] : 10'd0;
         end else if (pos == patsp_pkg::POS_STREAM) begin
            hdr_stream_id_in = {gather_shift_ff[7:0], b};
         end else if (pos == patsp_pkg::POS_VERSION) begin
            hdr_version_in      = b[5:1];
            hdr_current_next_in = b[0];
         end else if (pos == patsp_pkg::POS_SECTION) begin
            hdr_sect_num_in = b;
         end else if (pos == patsp_pkg::POS_LAST) begin
            hdr_last_section_in = b;
         end else if (is_summary) begin
            in_section_in    = 1'b0;
            byte_position_in = '0;
         end else begin
            in_section_in = 1'b1;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         byte_position_ff <= '0;
         in_section_ff    <= 1'b0;
      end else begin
         byte_position_ff <= byte_position_in;
         in_section_ff    <= in_section_in;
      end
   end

   // header fields, always written before they are read
   always_ff @(posedge clock) begin
      hdr_tbl_id_ff       <= hdr_tbl_id_in;
      hdr_syntax_ff       <= hdr_syntax_in;
      hdr_length_ff       <= hdr_length_in;
      hdr_stream_id_ff    <= hdr_stream_id_in;
      hdr_version_ff      <= hdr_version_in;
      hdr_current_next_ff <= hdr_current_next_in;
      hdr_sect_num_ff     <= hdr_sect_num_in;
      hdr_last_section_ff <= hdr_last_section_in;
      entry_total_ff      <= entry_total_in;
      gather_shift_ff     <= gather_shift_in;
   end

endmodule

`default_nettype wire

[rtl/core/pat_section_parser.sv]
// pat_section_parser: top level, input register, parser and result register
// depends on patsp_pkg and patsp_parse
//
// Usage: section bytes enter on the req_ channel, one byte per beat, with
// section_start high on the table id byte. A new section_start always opens
// a fresh section; an unfinished one is dropped silently. Bytes outside a
// section are consumed and produce nothing.
// Results leave on the rsp_ channel: one entry beat (kind 0) per four-byte
// program entry and one summary beat (kind 1) after the last crc byte.
// Bytes go from the input register through the parser to the result register.
// Throughput: one byte per cycle; the input register is drained into the
// parser each cycle unless the byte produces a result and the result
// register is full and stalled.
// When rsp_ready is low and the result register is full, bytes that make no
// result keep flowing; a byte that makes a result waits in the input
// register and req_ready drops until the held result is taken.
// Reset clears the section tracker and both beat valids; no section is open.
`timescale 1ns / 1ps
`default_nettype none

module pat_section_parser (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire patsp_pkg::req_type req_data,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output patsp_pkg::rsp_type      rsp_data
);

   logic               in_valid_ff, in_valid_in;
   patsp_pkg::req_type in_data_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   patsp_pkg::rsp_type rsp_data_ff;
   logic               res_valid;
   patsp_pkg::rsp_type res;
   logic               adv;
   logic               req_fire;

   // parser core
   patsp_parse u_parse (
      .clock     (clock),
      .reset     (reset),
      .step      (adv),
      .beat      (in_data_ff),
      .res_valid (res_valid),
      .res       (res)
   );

   // handshake and advance control
   always_comb begin
      adv          = in_valid_ff && (!res_valid || !rsp_valid_ff || rsp_ready);
      req_ready    = !in_valid_ff || adv;
      req_fire     = req_valid && req_ready;
      in_valid_in  = req_fire | (in_valid_ff & ~adv);
      rsp_valid_in = (adv && res_valid) | (rsp_valid_ff & ~rsp_ready);
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // beat payload registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_data_ff <= req_data;
      end
      if (adv && res_valid) begin
         rsp_data_ff <= res;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire
